[hw/rtl/sbusld_pkg.sv]
// Shared constants and controller/datapath interface types of the SBUS loss-window decoder.
`default_nettype none

package sbusld_pkg;

  localparam int          ChannelBits  = 11;
  localparam int          PayloadBytes = 22;
  localparam int          PayloadBits  = PayloadBytes * 8;
  localparam int          IndexBits    = 4;
  localparam int          QuotBits     = 7;
  localparam int          PercentScale = 100;
  localparam int          FlagLostBit  = 2;
  localparam logic [7:0]  HeaderByte   = 8'h0F;
  localparam logic [7:0]  FlagsBadMask = 8'hF0;
  localparam logic [7:0]  EndByte      = 8'h00;
  localparam logic [10:0] DigitalOn    = 11'd2000;
  localparam logic [10:0] DigitalOff   = 11'd1000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_cnt;
    logic shift_in;
    logic cap_flags;
    logic upd_win;
    logic div_start;
    logic emit_next;
  } sbusld_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic header_hit;
    logic pay_last;
    logic flags_bad;
    logic end_ok;
    logic div_last;
    logic emit_last;
  } sbusld_status_t;

endpackage

`default_nettype wire

[hw/rtl/sbusld_pct_div.sv]
// Percentage unit that scales the window loss count by 100 over the window length.
`default_nettype none

module sbusld_pct_div
  import sbusld_pkg::*;
#(
  parameter int WINDOW = 333,
  parameter int CW     = 9
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [CW-1:0]       count_i,
  output logic                     last_o,
  output logic [QuotBits-1:0]      quot_o
);

  // The dividend count * 100 stays below 2^XW. Multiplying it by the
  // rounded-up reciprocal 2^SH / WINDOW and dropping SH bits gives the exact
  // truncated quotient over that whole range. The constant 100 is folded
  // into the reciprocal, so a single multiplication remains.
  localparam int              XW     = $clog2(WINDOW * PercentScale + 1);
  localparam int              LW     = $clog2(WINDOW);
  localparam int              SH     = XW + LW;
  localparam longint unsigned Recip  = ((64'd1 << SH) + WINDOW - 1) / WINDOW;
  localparam longint unsigned Factor = Recip * PercentScale;
  localparam int              FW     = $clog2(Factor + 1);
  localparam int              PW     = CW + FW;

  logic [PW-1:0]       prod;
  logic [QuotBits-1:0] quot_q;
  logic                done_q;

  assign prod   = PW'(count_i) * PW'(Factor);
  assign last_o = done_q;
  assign quot_o = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= QuotBits'(prod >> SH);
    end
  end

endmodule

`default_nettype wire

[hw/rtl/sbusld_datapath.sv]
// Datapath: payload shift register, flags, loss window memory, counters and output fields.
`default_nettype none

module sbusld_datapath
  import sbusld_pkg::*;
#(
  parameter int WINDOW   = 333,
  parameter int CHANNELS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [7:0]           rx_byte_i,
  input  wire sbusld_cmd_t          cmd_i,
  output sbusld_status_t            status_o,
  output logic [IndexBits-1:0]      channel_index_o,
  output logic [ChannelBits-1:0]    channel_value_o,
  output logic [10:0]               digital_one_o,
  output logic [10:0]               digital_two_o,
  output logic                      frame_lost_o,
  output logic [8:0]                lost_in_window_o,
  output logic [QuotBits-1:0]       lost_percent_o,
  output logic [31:0]               lost_total_o
);

  localparam int CW = $clog2(WINDOW + 1);
  localparam int PW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  logic [4:0]             byte_cnt_q;
  logic [PayloadBits-1:0] pay_q;
  logic [7:0]             flags_q;
  logic [PW-1:0]          ptr_q;
  logic                   wrapped_q;
  logic [CW-1:0]          count_q;
  logic [CW-1:0]          count_d;
  logic [31:0]            total_q;
  logic [IndexBits-1:0]   idx_q;
  logic                   old_bit_q;
  logic                   old_eff;
  logic                   lost;
  logic                   win_mem [WINDOW];
  logic [CW+8:0]          count_ext;

  assign lost    = flags_q[FlagLostBit];
  // Entries at or past the pointer were never written until the pointer wraps once.
  assign old_eff = wrapped_q & old_bit_q;
  assign count_d = count_q - CW'(old_eff) + CW'(lost);

  assign status_o.header_hit = (rx_byte_i == HeaderByte);
  assign status_o.pay_last   = (byte_cnt_q == 5'(PayloadBytes - 1));
  assign status_o.flags_bad  = |(rx_byte_i & FlagsBadMask);
  assign status_o.end_ok     = (rx_byte_i == EndByte);
  assign status_o.emit_last  = (idx_q == IndexBits'(CHANNELS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_cnt_q <= 5'd0;
      ptr_q      <= '0;
      wrapped_q  <= 1'b0;
      count_q    <= '0;
      total_q    <= 32'd0;
      idx_q      <= '0;
    end else begin
      if (cmd_i.clr_cnt) begin
        byte_cnt_q <= 5'd0;
      end else if (cmd_i.shift_in) begin
        byte_cnt_q <= byte_cnt_q + 5'd1;
      end
      if (cmd_i.upd_win) begin
        count_q <= count_d;
        total_q <= total_q + 32'(lost);
        if (ptr_q == PW'(WINDOW - 1)) begin
          ptr_q     <= '0;
          wrapped_q <= 1'b1;
        end else begin
          ptr_q <= ptr_q + PW'(1);
        end
      end
      if (cmd_i.emit_next) begin
        idx_q <= status_o.emit_last ? '0 : idx_q + IndexBits'(1);
      end
    end
  end

  // Bytes enter at the top so that payload bit n ends up at vector bit n.
  always_ff @(posedge clk_i) begin
    if (cmd_i.shift_in) begin
      pay_q <= {rx_byte_i, pay_q[PayloadBits-1:8]};
    end else if (cmd_i.emit_next) begin
      pay_q <= pay_q >> ChannelBits;
    end
    if (cmd_i.cap_flags) begin
      flags_q <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd_win) begin
      win_mem[ptr_q] <= lost;
    end
    old_bit_q <= win_mem[ptr_q];
  end

  sbusld_pct_div #(
    .WINDOW (WINDOW),
    .CW     (CW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .count_i (count_q),
    .last_o  (status_o.div_last),
    .quot_o  (lost_percent_o)
  );

  assign count_ext        = {{9{1'b0}}, count_q};
  assign channel_index_o  = idx_q;
  assign channel_value_o  = pay_q[ChannelBits-1:0];
  assign digital_one_o    = flags_q[0] ? DigitalOn : DigitalOff;
  assign digital_two_o    = flags_q[1] ? DigitalOn : DigitalOff;
  assign frame_lost_o     = lost;
  assign lost_in_window_o = count_ext[8:0];
  assign lost_total_o     = total_q;

endmodule

`default_nettype wire

[hw/rtl/sbusld_ctrl.sv]
// Controller state machine that sequences frame reception, window update, divide and burst.
`default_nettype none

module sbusld_ctrl
  import sbusld_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  wire sbusld_status_t status_i,
  output sbusld_cmd_t         cmd_o
);

  typedef enum logic [7:0] {
    S_HUNT  = 8'b0000_0001,
    S_PAY   = 8'b0000_0010,
    S_FLAGS = 8'b0000_0100,
    S_END   = 8'b0000_1000,
    S_UPD   = 8'b0001_0000,
    S_LOAD  = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   in_fire;
  logic   out_fire;

  assign in_ready_o  = state_q inside {S_HUNT, S_PAY, S_FLAGS, S_END};
  assign out_valid_o = (state_q == S_EMIT);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_o && out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_HUNT: begin
        if (in_fire && status_i.header_hit) begin
          cmd_o.clr_cnt = 1'b1;
          state_d       = S_PAY;
        end
      end
      S_PAY: begin
        if (in_fire) begin
          cmd_o.shift_in = 1'b1;
          if (status_i.pay_last) begin
            state_d = S_FLAGS;
          end
        end
      end
      S_FLAGS: begin
        if (in_fire) begin
          if (status_i.flags_bad) begin
            state_d = S_HUNT;
          end else begin
            cmd_o.cap_flags = 1'b1;
            state_d         = S_END;
          end
        end
      end
      S_END: begin
        if (in_fire) begin
          state_d = status_i.end_ok ? S_UPD : S_HUNT;
        end
      end
      S_UPD: begin
        cmd_o.upd_win = 1'b1;
        state_d       = S_LOAD;
      end
      S_LOAD: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        if (status_i.div_last) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_fire) begin
          cmd_o.emit_next = 1'b1;
          if (status_i.emit_last) begin
            state_d = S_HUNT;
          end
        end
      end
      default: begin
        state_d = S_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_HUNT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/sbus_frame_decoder_loss_window.sv]
// Top level of the SBUS frame decoder with a sliding frame-loss window.
//
// Input channel: one received SBUS byte per beat on rx_byte_i, handshaked by
// in_valid_i and in_ready_o. The block hunts for the 0x0F header, collects the
// 22 payload bytes and the flags byte, and checks the end byte. A flags byte
// with any upper-nibble bit set, or a nonzero end byte, drops the frame.
// Output channel: for each good frame a burst of CHANNELS beats, one per
// 11-bit channel, handshaked by out_valid_o and out_ready_i. Every beat also
// carries the digital channels, the lost flag, the window loss count, its
// percentage and the lost total; last_of_frame_o marks the final beat.
// While receiving, one byte is taken per cycle. After a good end byte the
// input is closed: the UPD state updates the loss window memory (its old
// entry was read in the end-byte cycle), the LOAD state forms the percentage
// with a reciprocal multiplication, and the DIV state hands it to the burst.
// Beats then follow in the EMIT state, one per cycle while out_ready_i is
// high. A stalled receiver simply holds the current beat and the block takes
// no byte until the last beat is gone. Reset returns to header hunting and
// empties the window; window entries not yet written since reset read as zero
// until the write pointer has wrapped once, so no clearing pass runs.
`default_nettype none

module sbus_frame_decoder_loss_window
  import sbusld_pkg::*;
#(
  parameter int WINDOW   = 333,
  parameter int CHANNELS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [7:0]           rx_byte_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [IndexBits-1:0]      channel_index_o,
  output logic [ChannelBits-1:0]    channel_value_o,
  output logic [10:0]               digital_one_o,
  output logic [10:0]               digital_two_o,
  output logic                      frame_lost_o,
  output logic [8:0]                lost_in_window_o,
  output logic [QuotBits-1:0]       lost_percent_o,
  output logic [31:0]               lost_total_o,
  output logic                      last_of_frame_o
);

  sbusld_cmd_t    cmd;
  sbusld_status_t status;

  // The controller owns both handshakes; the datapath only sees commands.
  sbusld_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sbusld_datapath #(
    .WINDOW   (WINDOW),
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .rx_byte_i        (rx_byte_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .channel_index_o  (channel_index_o),
    .channel_value_o  (channel_value_o),
    .digital_one_o    (digital_one_o),
    .digital_two_o    (digital_two_o),
    .frame_lost_o     (frame_lost_o),
    .lost_in_window_o (lost_in_window_o),
    .lost_percent_o   (lost_percent_o),
    .lost_total_o     (lost_total_o)
  );

  assign last_of_frame_o = status.emit_last;

  // Bytes are never taken while a burst is pending or being delivered.
  a_no_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input open while a burst is pending");

  // Channel indexes advance by one within a burst.
  a_index_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_of_frame_o |=>
      out_valid_o && (channel_index_o == $past(channel_index_o) + IndexBits'(1)))
    else $error("channel index did not advance by one");

  // The burst ends right after its last beat is taken.
  a_burst_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_of_frame_o |=> !out_valid_o && in_ready_o)
    else $error("burst did not end after its last beat");

  // The percentage never exceeds one hundred.
  a_pct_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (lost_percent_o <= QuotBits'(PercentScale)))
    else $error("loss percentage out of range");

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for the SBUS frame decoder with its frame-loss window.
`timescale 1ns / 100ps

module tb_top
  import sbusld_pkg::*;
();

  // The DUT runs with its default window and channel count; the predictor
  // below mirrors those same numbers.
  localparam int WindowLen   = 333;
  localparam int NumChannels = 16;
  // The limit sits far above the slowest legal run, so this only trips on a hang.
  localparam int CycleLimit  = 100000;
  localparam int IdleMax     = 14;
  // Long receiver hold-offs, counted in cycles, to back up the block and stall its input.
  localparam int LongHold    = 600;

  typedef enum int {
    FillZero,
    FillOnes,
    FillHeaderMix,
    FillRandom
  } fill_mode_e;

  // One output beat, field by field, at the widths of the ports.
  typedef struct {
    logic [3:0]  index;
    logic [10:0] value;
    logic [10:0] digital_one;
    logic [10:0] digital_two;
    logic        lost;
    logic [8:0]  in_window;
    logic [6:0]  percent;
    logic [31:0] total;
    logic        last;
  } chan_beat_t;

  // Tracks the decoder state from the accepted bytes and holds the channel beats that each
  // good frame is owed. Beats are matched in order against what the DUT delivers.
  class sbus_burst_tracker;
    int          frame_pos;
    logic [7:0]  payload [PayloadBytes];
    logic [7:0]  flags_q;
    bit          lost_hist [WindowLen];
    int          hist_ptr;
    int unsigned hist_lost;
    logic [31:0] lost_sum;
    chan_beat_t  owed_beats [$];
    int          errors;

    function new();
      frame_pos = 0;
      flags_q   = '0;
      hist_ptr  = 0;
      hist_lost = 0;
      lost_sum  = '0;
      errors    = 0;
      foreach (payload[i]) payload[i] = '0;
      foreach (lost_hist[i]) lost_hist[i] = 1'b0;
    endfunction

    function int pending();
      return owed_beats.size();
    endfunction

    // Advance the frame parser by one accepted byte.
    function void take_byte(logic [7:0] b);
      logic [PayloadBits-1:0] bitstream;
      chan_beat_t             e;
      bit                     lost;
      if (frame_pos == 0) begin
        if (b == HeaderByte) frame_pos = 1;
        return;
      end
      if (frame_pos <= PayloadBytes) begin
        payload[frame_pos-1] = b;
        frame_pos++;
        return;
      end
      if (frame_pos == PayloadBytes + 1) begin
        if ((b & FlagsBadMask) != 8'h00) begin
          frame_pos = 0;
        end else begin
          flags_q   = b;
          frame_pos = PayloadBytes + 2;
        end
        return;
      end
      frame_pos = 0;
      if (b != EndByte) return;

      // Good frame: slide the loss window, then queue one beat per channel.
      lost      = flags_q[FlagLostBit];
      lost_sum  = lost_sum + lost;
      hist_lost = hist_lost - lost_hist[hist_ptr] + lost;
      lost_hist[hist_ptr] = lost;
      hist_ptr  = (hist_ptr + 1) % WindowLen;
      for (int i = 0; i < PayloadBytes; i++) bitstream[i*8 +: 8] = payload[i];
      for (int k = 0; k < NumChannels; k++) begin
        e.index       = k[3:0];
        e.value       = bitstream[k*ChannelBits +: ChannelBits];
        e.digital_one = flags_q[0] ? DigitalOn : DigitalOff;
        e.digital_two = flags_q[1] ? DigitalOn : DigitalOff;
        e.lost        = lost;
        e.in_window   = hist_lost[8:0];
        e.percent     = 7'((hist_lost * PercentScale) / WindowLen);
        e.total       = lost_sum;
        e.last        = (k == NumChannels - 1);
        owed_beats.push_back(e);
      end
    endfunction

    function void check_field(string name, longint unsigned exp_v, longint unsigned act_v);
      if (exp_v != act_v) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    // Compare one delivered beat with the oldest owed beat.
    function void match_beat(chan_beat_t a);
      chan_beat_t e;
      if (owed_beats.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual channel %0d value %0d",
                 $time, a.index, a.value);
        errors++;
        return;
      end
      e = owed_beats.pop_front();
      check_field("channel_index", e.index, a.index);
      check_field("channel_value", e.value, a.value);
      check_field("digital_one", e.digital_one, a.digital_one);
      check_field("digital_two", e.digital_two, a.digital_two);
      check_field("frame_lost", e.lost, a.lost);
      check_field("lost_in_window", e.in_window, a.in_window);
      check_field("lost_percent", e.percent, a.percent);
      check_field("lost_total", e.total, a.total);
      check_field("last_of_frame", e.last, a.last);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [3:0]  channel_index_o;
  logic [10:0] channel_value_o;
  logic [10:0] digital_one_o;
  logic [10:0] digital_two_o;
  logic        frame_lost_o;
  logic [8:0]  lost_in_window_o;
  logic [6:0]  lost_percent_o;
  logic [31:0] lost_total_o;
  logic        last_of_frame_o;

  sbus_burst_tracker sb = new();

  // Payload of the frame about to be sent, and whether the sender currently runs gap-free.
  logic [7:0]  frame_buf [PayloadBytes];
  bit          send_quiet;
  int          bytes_sent;
  int          cycle_count;

  sbus_frame_decoder_loss_window #(
    .WINDOW   (WindowLen),
    .CHANNELS (NumChannels)
  ) uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .channel_index_o  (channel_index_o),
    .channel_value_o  (channel_value_o),
    .digital_one_o    (digital_one_o),
    .digital_two_o    (digital_two_o),
    .frame_lost_o     (frame_lost_o),
    .lost_in_window_o (lost_in_window_o),
    .lost_percent_o   (lost_percent_o),
    .lost_total_o     (lost_total_o),
    .last_of_frame_o  (last_of_frame_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake or a missing beat ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Output monitor. Sampling right at the rising edge sees the values that the DUT
  // presented during the cycle, before its registers update.
  always @(posedge clk_i) begin : beat_monitor
    chan_beat_t a;
    if (rst_ni && out_valid_o && out_ready_i) begin
      a.index       = channel_index_o;
      a.value       = channel_value_o;
      a.digital_one = digital_one_o;
      a.digital_two = digital_two_o;
      a.lost        = frame_lost_o;
      a.in_window   = lost_in_window_o;
      a.percent     = lost_percent_o;
      a.total       = lost_total_o;
      a.last        = last_of_frame_o;
      sb.match_beat(a);
    end
  end

  // Receiver side. Ready may drop for a random stretch before each beat, with some
  // bursts taken back to back. Twice it holds off for a long stretch so the block fills up
  // and closes its input while the sender keeps offering bytes.
  initial begin : receiver
    int  wait_cycles;
    int  beats_taken;
    bit  rx_quiet;
    beats_taken = 0;
    rx_quiet    = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (beats_taken % NumChannels == 0) rx_quiet = ($urandom_range(0, 3) == 0);
      wait_cycles = rx_quiet ? 0 : $urandom_range(0, IdleMax);
      if (beats_taken == 40 || beats_taken == 72) wait_cycles = LongHold;
      if (wait_cycles > 0) begin
        out_ready_i <= 1'b0;
        repeat (wait_cycles) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      beats_taken++;
      @(negedge clk_i);
    end
  end

  // Offer one byte, after a random gap, and hold it until accepted. Called at a falling
  // edge and returns at the falling edge after acceptance, so valid is written only once
  // per step: either kept high for the next byte or lowered for a gap.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = send_quiet ? 0 : $urandom_range(0, IdleMax);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    sb.take_byte(b);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  function automatic void fill_payload(fill_mode_e mode);
    foreach (frame_buf[i]) begin
      case (mode)
        FillZero:      frame_buf[i] = 8'h00;
        FillOnes:      frame_buf[i] = 8'hFF;
        FillHeaderMix: frame_buf[i] = i[0] ? FlagsBadMask : HeaderByte;
        default: begin
          // A header value now and then inside the payload must be taken as data.
          frame_buf[i] = ($urandom_range(0, 7) == 0) ? HeaderByte : 8'($urandom_range(0, 255));
        end
      endcase
    end
  endfunction

  // Header, the payload in frame_buf, flags and end byte. Gap-free frames come up at random.
  task automatic send_frame(input logic [7:0] flags, input logic [7:0] end_b);
    send_quiet = ($urandom_range(0, 3) == 0);
    send_byte(HeaderByte);
    foreach (frame_buf[i]) send_byte(frame_buf[i]);
    send_byte(flags);
    send_byte(end_b);
  endtask

  // Close the input and wait until every owed beat has arrived, then let the clock run on
  // with the input idle. The watchdog covers a beat that never comes.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (40) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin : stimulus
    int         rand_start;
    int         pick;
    int         cut;
    logic [7:0] flags;
    logic [7:0] end_b;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    rx_byte_i   = 8'h00;
    out_ready_i = 1'b0;
    send_quiet  = 1'b0;
    bytes_sent  = 0;
    cycle_count = 0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part. Noise while hunting must be ignored.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h0E);
    send_byte(8'h1F);
    // All-zero and all-one payloads give the channel value extremes; flags cover every
    // digital combination and the lost bit, with bit 3 set as a legal lower-nibble bit.
    fill_payload(FillZero);
    send_frame(8'h00, EndByte);
    fill_payload(FillOnes);
    send_frame(8'h0F, EndByte);
    // Header values inside a frame are plain data.
    fill_payload(FillHeaderMix);
    send_frame(8'h01, EndByte);
    // A bad flags byte drops the frame, and the very next byte is checked as a header.
    fill_payload(FillRandom);
    send_frame(8'h10, EndByte);
    fill_payload(FillRandom);
    send_frame(8'h02, EndByte);
    fill_payload(FillRandom);
    send_frame(8'h80, 8'h0F);
    // Nonzero end bytes drop the frame.
    fill_payload(FillRandom);
    send_frame(8'h04, 8'h80);
    fill_payload(FillRandom);
    send_frame(8'h04, 8'h01);
    fill_payload(FillRandom);
    send_frame(8'h07, EndByte);
    wait_idle();

    // Random part: mostly well-formed frames with random content, the rest noise,
    // truncated frames and frames with broken flags or end bytes.
    rand_start = bytes_sent;
    while (bytes_sent - rand_start < 120) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        fill_payload(FillRandom);
        flags = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(16, 255))
                                            : 8'($urandom_range(0, 15));
        end_b = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : EndByte;
        send_frame(flags, end_b);
      end else if (pick < 9) begin
        send_quiet = ($urandom_range(0, 1) == 0);
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end else begin
        send_quiet = 1'b0;
        cut = $urandom_range(1, PayloadBytes + 1);
        send_byte(HeaderByte);
        repeat (cut) send_byte(8'($urandom_range(0, 255)));
      end
    end
    // Sender pause until the block has delivered everything it owes.
    wait_idle();

    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[sbus_frame_decoder_loss_window.f]
hw/rtl/sbusld_pkg.sv
hw/rtl/sbusld_pct_div.sv
hw/rtl/sbusld_datapath.sv
hw/rtl/sbusld_ctrl.sv
hw/rtl/sbus_frame_decoder_loss_window.sv
tb/tb_top.sv
